FILE: sv/fbpa_pkg.sv
// fbpa_pkg: shared widths, codes, divider link types and helpers of the block pool allocator
package fbpa_pkg;

	// field widths
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned LINK_W     = 9;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// index times block size
	localparam int unsigned PROD_W = LINK_W + SIZE_W;
	// divider step counter, one quotient bit per step
	localparam int unsigned STEP_W = $clog2(LINK_W + 1);

	localparam int unsigned DEF_NUM_BLOCKS = 256;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BSIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BCOUNT = 2'd2;

	// register reset values
	localparam logic [ADDR_W-1:0] RST_BASE   = '0;
	localparam logic [SIZE_W-1:0] RST_BSIZE  = 16'd16;
	localparam logic [LINK_W-1:0] RST_BCOUNT = 9'd256;

	// divider request and result
	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [LINK_W-1:0] quotient;
	} div_res_t;

	// free blocks left for a given use count and pool size
	function automatic logic [LINK_W-1:0] free_of(input logic [LINK_W-1:0] used,
			input logic [LINK_W-1:0] cnt);
		return (used < cnt) ? (cnt - used) : '0;
	endfunction

endpackage

FILE: sv/fbpa_if.sv
// fbpa_if: request, response and register write channels of the block pool allocator

// request word: command and address
interface fbpa_req_if import fbpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output command, output address, input ready);
	modport sink (input valid, input command, input address, output ready);
endinterface

// response word: status, block address and free count
interface fbpa_rsp_if import fbpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ADDR_W-1:0] block_address;
	logic [LINK_W-1:0] free_blocks;

	modport source (output valid, output status, output block_address, output free_blocks,
		input ready);
	modport sink (input valid, input status, input block_address, input free_blocks,
		output ready);
endinterface

// register write word
interface fbpa_cfg_if import fbpa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/fbpa_link_ram.sv
// fbpa_link_ram: single-port-write link store with one registered read port
module fbpa_link_ram import fbpa_pkg::*; #(
	parameter int unsigned DEPTH = DEF_NUM_BLOCKS,
	parameter int unsigned AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [LINK_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [LINK_W-1:0] rdata
);

	logic [LINK_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/fbpa_div.sv
// fbpa_div: restoring divider, one quotient bit per cycle, for in-pool offsets
module fbpa_div import fbpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_res_t res
);

	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [LINK_W-1:0] dvd_q;
	logic [LINK_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SIZE_W:0]   trial;
	logic              fits;
	logic [SIZE_W:0]   diff;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, dvd_q[LINK_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(LINK_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient; the offset lies below divisor times 2^LINK_W,
	// so its upper bits start below the divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[LINK_W +: SIZE_W];
			dvd_q <= req.dividend[LINK_W-1:0];
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			dvd_q <= {dvd_q[LINK_W-2:0], 1'b0};
			quo_q <= {quo_q[LINK_W-2:0], fits};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

FILE: sv/fixed_block_pool_allocator_unit.sv
// fixed_block_pool_allocator_unit: block pool allocator with a LIFO free list in a link RAM
// allocate: S_ALLOC registers the popped block's address, then S_DONE loads the output register
// free: range check then the 9-step divider, then S_DONE loads the output register
// rejected free: S_CHECK then S_DONE; empty-pool allocate: straight to S_DONE
// one word at a time; a finished result waits in the output register while the next is taken
// after reset an init pass writes each link RAM entry with the next index, no word taken meanwhile
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
	parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS
) (
	input  logic       clk,
	input  logic       arst_n,
	fbpa_cfg_if.sink   cfg,
	fbpa_req_if.sink   req,
	fbpa_rsp_if.source rsp
);

	localparam int unsigned AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_ALLOC,
		S_CHECK,
		S_DIV,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     init_cnt_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] used_q;

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] bsize_q;
	logic [LINK_W-1:0] bcount_q;

	logic [PROD_W-1:0] mul_q;
	logic [ADDR_W-1:0] offset_q;
	logic [ADDR_W-1:0] addr_q;
	logic              lo_ok_q;

	logic [STAT_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [LINK_W-1:0] res_free_q;

	logic              rsp_valid_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic [LINK_W-1:0] rsp_free_q;

	logic [LINK_W-1:0] pcount;
	logic [LINK_W-1:0] free_now;
	logic [LINK_W-1:0] mul_a;
	logic              req_fire;
	logic              head_lt;
	logic              idx_lt;
	logic [ADDR_W:0]   hi_bound;
	logic              in_rng;
	logic [LINK_W-1:0] used_inc;
	logic [LINK_W-1:0] used_dec;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [LINK_W-1:0] ram_rdata;

	div_req_t          div_req;
	div_res_t          div_res;

	// pool size and free count
	assign pcount   = (32'(bcount_q) > 32'(NUM_BLOCKS)) ? LINK_W'(NUM_BLOCKS) : bcount_q;
	assign free_now = free_of(used_q, pcount);
	assign used_inc = used_q + LINK_W'(1);
	assign used_dec = (used_q != '0) ? (used_q - LINK_W'(1)) : '0;

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.free_blocks   = rsp_free_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= RST_BASE;
			bsize_q  <= RST_BSIZE;
			bcount_q <= RST_BCOUNT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BASE: begin
					base_q <= cfg.data[ADDR_W-1:0];
				end
				REG_BSIZE: begin
					bsize_q <= cfg.data[SIZE_W-1:0];
				end
				REG_BCOUNT: begin
					bcount_q <= cfg.data[LINK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// shared multiplier: head times size on allocate, pool span on free
	assign mul_a = (req.command == CMD_FREE) ? pcount : head_q;

	always_ff @(posedge clk) begin
		if (req_fire) begin
			mul_q    <= {{SIZE_W{1'b0}}, mul_a} * {{LINK_W{1'b0}}, bsize_q};
			offset_q <= req.address - base_q;
			addr_q   <= req.address;
			lo_ok_q  <= req.address >= base_q;
		end
	end

	// upper bound taken without wrap
	assign hi_bound = {1'b0, base_q} + (ADDR_W + 1)'(mul_q);
	assign in_rng   = lo_ok_q && ({1'b0, addr_q} < hi_bound) && (bsize_q != '0);

	// link store access
	assign head_lt   = 32'(head_q) < 32'(NUM_BLOCKS);
	assign idx_lt    = 32'(div_res.quotient) < 32'(NUM_BLOCKS);
	assign ram_raddr = AW'(32'(head_q));
	assign ram_we    = (state_q == S_INIT) || ((state_q == S_DIV) && div_res.done && idx_lt);
	assign ram_waddr = (state_q == S_INIT) ? init_cnt_q : AW'(32'(div_res.quotient));
	assign ram_wdata = (state_q == S_INIT) ? LINK_W'(32'(init_cnt_q) + 32'd1) : head_q;

	fbpa_link_ram #(
		.DEPTH (NUM_BLOCKS),
		.AW    (AW)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// divider
	assign div_req.start    = (state_q == S_CHECK) && in_rng;
	assign div_req.dividend = offset_q;
	assign div_req.divisor  = bsize_q;

	fbpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			init_cnt_q   <= '0;
			head_q       <= '0;
			used_q       <= '0;
			res_status_q <= ST_OK;
			res_addr_q   <= '0;
			res_free_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_addr_q   <= '0;
			rsp_free_q   <= '0;
		end else begin
			// the hand-over state reloads the output register itself
			if (rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + AW'(1);
					if (init_cnt_q == AW'(NUM_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						if (req.command == CMD_FREE) begin
							state_q <= S_CHECK;
						end else if (free_now == '0) begin
							res_status_q <= ST_EMPTY;
							res_addr_q   <= '0;
							res_free_q   <= free_now;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_ALLOC;
						end
					end
				end
				S_ALLOC: begin
					// pop the head; link data arrives in the cycle after the read
					head_q       <= head_lt ? ram_rdata : '0;
					used_q       <= used_inc;
					res_status_q <= ST_OK;
					res_addr_q   <= base_q + ADDR_W'(mul_q);
					res_free_q   <= free_of(used_inc, pcount);
					state_q      <= S_DONE;
				end
				S_CHECK: begin
					if (in_rng) begin
						state_q <= S_DIV;
					end else begin
						res_status_q <= ST_RANGE;
						res_addr_q   <= '0;
						res_free_q   <= free_now;
						state_q      <= S_DONE;
					end
				end
				S_DIV: begin
					// push the freed block; its link takes the old head
					if (div_res.done) begin
						head_q       <= div_res.quotient;
						used_q       <= used_dec;
						res_status_q <= ST_OK;
						res_addr_q   <= '0;
						res_free_q   <= free_of(used_dec, pcount);
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_addr_q   <= res_addr_q;
						rsp_free_q   <= res_free_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a new response word only comes out of the hand-over state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside hand-over");

	// free count never exceeds the pool size
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_free_q <= pcount)
		else $error("free count above pool size");

	// only an ok allocate carries an address
	a_err_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q != ST_OK) |-> rsp_addr_q == '0)
		else $error("error response with nonzero address");

	// the divider finishes only while a free waits for it
	a_div_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider result outside free");

	// the use count moves only when an allocate or a free completes
	a_used_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_q) |-> ($past(state_q) == S_ALLOC || $past(state_q) == S_DIV))
		else $error("use count changed outside allocate or free");

endmodule
